// ===== src/wstd_pkg.sv =====
package wstd_pkg;

	localparam int NUM_WORKERS_DEF = 4;
	localparam int DEQUE_DEPTH_DEF = 1 << 10;
	localparam int TASK_WIDTH_DEF  = 32;

	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LOCAL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STOLEN   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_REQ = 1'b1;

endpackage

// ===== src/work_stealing_task_dispatcher_unit.sv =====
// Result: the strobe (done) rises in the cycle after start is taken.
// Start is not taken while busy is high; busy covers the cycle in which
// the single-port token memory returns its registered read data.
// Reset: arst_n clears all deque heads, counts and the handshake state; token
// memory contents are left as they are. The receiver cannot stall results.
module work_stealing_task_dispatcher_unit import wstd_pkg::*; #(
	parameter int NUM_WORKERS = NUM_WORKERS_DEF,
	parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
	parameter int TASK_WIDTH  = TASK_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [1:0]          worker_id,
	input  logic [31:0]         task_req,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [31:0]         task_out,
	output logic [1:0]          victim
);

	localparam int WW = $clog2(NUM_WORKERS);
	localparam int PW = $clog2(DEQUE_DEPTH);
	localparam int CW = $clog2(DEQUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int AW = WW + PW;

	logic [PW-1:0] head_q  [NUM_WORKERS];
	logic [CW-1:0] count_q [NUM_WORKERS];
	logic          busy_q;
	logic          done_q;
	logic [STATUS_W-1:0] status_s1;
	logic          rd_s1;
	logic [1:0]    victim_s1;

	logic          accept;
	logic [4:0]    wid_ext;
	logic          wid_ok;
	logic [WW-1:0] w_idx;
	logic [CW-1:0] own_cnt;
	logic          found;
	logic [WW-1:0] vic_idx;
	logic [WW:0]   cand;
	logic [WW-1:0] cand_idx;
	logic [STATUS_W-1:0] st_n;
	logic          we;
	logic          rd_n;
	logic [WW-1:0] sel_w;
	logic [CW-1:0] off;
	logic [SW-1:0] sum;
	logic [PW-1:0] slot;
	logic [AW-1:0] addr;
	logic [63:0]   req_ext;
	logic [TASK_WIDTH-1:0] wr_tok;
	logic [TASK_WIDTH-1:0] rd_tok;
	logic [63:0]   rd_ext;
	logic [4:0]    vic_ext;

	assign accept  = start && !busy_q;
	assign wid_ext = 5'(worker_id);
	assign wid_ok  = 32'(wid_ext) < NUM_WORKERS;
	assign w_idx   = wid_ext[WW-1:0];
	assign own_cnt = count_q[w_idx];

	always_comb begin
		found    = 1'b0;
		vic_idx  = '0;
		cand     = '0;
		cand_idx = '0;
		for (int k = NUM_WORKERS - 1; k >= 1; k--) begin
			cand = (WW+1)'(w_idx) + (WW+1)'(NUM_WORKERS - k);
			if (cand >= (WW+1)'(NUM_WORKERS)) begin
				cand = cand - (WW+1)'(NUM_WORKERS);
			end
			cand_idx = cand[WW-1:0];
			if (count_q[cand_idx] != '0) begin
				found   = 1'b1;
				vic_idx = cand_idx;
			end
		end
	end

	always_comb begin
		st_n  = ST_NONE;
		we    = 1'b0;
		rd_n  = 1'b0;
		sel_w = w_idx;
		off   = '0;
		priority if (!wid_ok) begin
			st_n = (mode == MODE_ENQ) ? ST_FULL : ST_NONE;
		end else if (mode == MODE_ENQ) begin
			if (own_cnt == CW'(DEQUE_DEPTH)) begin
				st_n = ST_FULL;
			end else begin
				st_n = ST_ENQUEUED;
				we   = accept;
				off  = own_cnt;
			end
		end else if (own_cnt != '0) begin
			st_n = ST_LOCAL;
			rd_n = 1'b1;
			off  = own_cnt - CW'(1);
		end else if (found) begin
			st_n  = ST_STOLEN;
			rd_n  = 1'b1;
			sel_w = vic_idx;
		end else begin
			st_n = ST_NONE;
		end
	end

	assign sum  = SW'(head_q[sel_w]) + SW'(off);
	assign slot = (sum >= SW'(DEQUE_DEPTH)) ? PW'(sum - SW'(DEQUE_DEPTH)) : PW'(sum);
	assign addr = {sel_w, slot};

	assign req_ext = 64'(task_req);
	assign wr_tok  = req_ext[TASK_WIDTH-1:0];

	wstd_ram #(
		.WIDTH(TASK_WIDTH),
		.DEPTH(1 << AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wr_tok),
		.rdata(rd_tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_WORKERS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			busy_q <= accept;
			done_q <= accept;
			if (accept) begin
				unique case (st_n)
					ST_ENQUEUED: count_q[w_idx] <= own_cnt + CW'(1);
					ST_LOCAL:    count_q[w_idx] <= own_cnt - CW'(1);
					ST_STOLEN: begin
						count_q[vic_idx] <= count_q[vic_idx] - CW'(1);
						head_q[vic_idx]  <= (head_q[vic_idx] == PW'(DEQUE_DEPTH - 1)) ?
							'0 : head_q[vic_idx] + PW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	assign vic_ext = 5'(vic_idx);

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_n;
			rd_s1     <= rd_n;
			victim_s1 <= (st_n == ST_STOLEN) ? vic_ext[1:0] : 2'd0;
		end
	end

	assign rd_ext   = 64'(rd_tok);
	assign busy     = busy_q;
	assign done     = done_q;
	assign status   = status_s1;
	assign task_out = rd_s1 ? rd_ext[31:0] : 32'd0;
	assign victim   = victim_s1;

endmodule

// ===== src/wstd_ram.sv =====
module wstd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule
